@@ hdl/gcnm_pkg.sv @@
`default_nettype none
package gcnm_pkg;

    localparam int ENTRY_W = 10;
    localparam int SCORE_W = 16;
    localparam int FU_W = 16;
    localparam int CALIPER_W = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    localparam int MAX_CONTROLS_DEF = 1024;
    localparam int NUM_CELLS = 8;
    localparam int CELL_W = $clog2(NUM_CELLS);

    localparam logic [CALIPER_W-1:0] CALIPER_RST = 17'd65536;
    localparam logic [FU_W-1:0] WINDOW_RST = 16'd90;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MATCH = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALIPER = 1'b0,
        CFG_WINDOW  = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_REDUCE,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic               found;
        logic [ENTRY_W-1:0] match_index;
    } t_res;

    typedef struct packed {
        logic [1:0]         operation;
        logic [ENTRY_W-1:0] entry_index;
        logic [SCORE_W-1:0] score;
        logic [FU_W-1:0]    follow_up;
    } t_cmd;

    typedef struct packed {
        logic               have;
        logic [SCORE_W-1:0] score_gap;
        logic [ENTRY_W-1:0] gidx;
    } t_cand;

    typedef struct packed {
        logic data_we;
        logic flag_we;
        logic flag_valid;
        logic flag_used;
        logic scan_vld;
        logic best_clr;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ hdl/gcnm_ram.sv @@
`default_nettype none
module gcnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hdl/gcnm_cell.sv @@
`default_nettype none
module gcnm_cell import gcnm_pkg::*; #(
    parameter int ROWS = 128,
    parameter int ROW_W = 7,
    parameter int CELL_ID = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [ROW_W-1:0]     i_wr_row,
    input  wire logic [ROW_W-1:0]     i_rd_row,
    input  wire logic [ROW_W-1:0]     i_scan_row,
    input  wire logic [SCORE_W-1:0]   i_ld_score,
    input  wire logic [FU_W-1:0]      i_ld_fu,
    input  wire logic [SCORE_W-1:0]   i_case_score,
    input  wire logic [FU_W-1:0]      i_case_fu,
    input  wire logic [CALIPER_W-1:0] i_caliper,
    input  wire logic [FU_W-1:0]      i_window,
    input  wire t_cand                i_chain,
    output t_cand                     o_chain
);

    localparam logic [CELL_W-1:0] MY_CELL = CELL_W'(CELL_ID);

    logic [SCORE_W+FU_W-1:0] data_rd;
    logic [1:0]              flag_rd;
    logic [SCORE_W-1:0]      ent_score;
    logic [FU_W-1:0]         ent_fu;
    logic [SCORE_W-1:0]      cand_gap;
    logic [FU_W-1:0]         fdiff;
    logic                    hit;
    logic                    closer;
    logic [ROW_W+CELL_W-1:0] gidx_full;
    t_cand                   r_best;
    t_cand                   r_chain;
    t_cand                   n_chain;

    gcnm_ram #(
        .WIDTH(SCORE_W + FU_W),
        .DEPTH(ROWS)
    ) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.data_we),
        .i_waddr(i_wr_row),
        .i_wdata({i_ld_score, i_ld_fu}),
        .i_raddr(i_rd_row),
        .o_rdata(data_rd)
    );

    gcnm_ram #(
        .WIDTH(2),
        .DEPTH(ROWS)
    ) u_flag_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.flag_we),
        .i_waddr(i_wr_row),
        .i_wdata({i_ctl.flag_valid, i_ctl.flag_used}),
        .i_raddr(i_rd_row),
        .o_rdata(flag_rd)
    );

    assign ent_score = data_rd[SCORE_W+FU_W-1:FU_W];
    assign ent_fu = data_rd[FU_W-1:0];
    assign cand_gap = (i_case_score >= ent_score) ? (i_case_score - ent_score)
                                                  : (ent_score - i_case_score);
    assign fdiff = (i_case_fu >= ent_fu) ? (i_case_fu - ent_fu) : (ent_fu - i_case_fu);
    assign hit = flag_rd[1] && !flag_rd[0] && (fdiff <= i_window)
                 && ({1'b0, cand_gap} < i_caliper);
    assign closer = !r_best.have || (cand_gap < r_best.score_gap);
    assign gidx_full = {i_scan_row, MY_CELL};

    always_comb begin
        n_chain = i_chain;
        if (r_best.have) begin
            if (!i_chain.have || (r_best.score_gap < i_chain.score_gap)
                || ((r_best.score_gap == i_chain.score_gap)
                    && (r_best.gidx < i_chain.gidx))) begin
                n_chain = r_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
            r_chain <= '0;
        end else begin
            r_chain <= n_chain;
            if (i_ctl.best_clr) begin
                r_best.have <= 1'b0;
            end else if (i_ctl.scan_vld && hit && closer) begin
                r_best.have <= 1'b1;
                r_best.score_gap <= cand_gap;
                r_best.gidx <= ENTRY_W'(gidx_full);
            end
        end
    end

    assign o_chain = r_chain;

endmodule
`default_nettype wire

@@ hdl/greedy_caliper_nearest_match.sv @@
// Greedy caliper matcher. The table is spread over a row of eight cells, each with its own
// bank, and entry i lives in cell i mod 8. A load beat leaves busy low. A match beat reads
// all banks in parallel, one row per cycle, then hands the best candidates down the cell
// row with busy high, and the single result beat is strobed in the first cycle with busy
// low again. A clear beat, and reset as well, sweeps the mark memories with busy high.
// Results cannot be held off: the receiver must take each beat in the cycle it is strobed.
`default_nettype none
module greedy_caliper_nearest_match import gcnm_pkg::*; #(
    parameter int MAX_CONTROLS = MAX_CONTROLS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_cmd                  i_cmd,
    output logic                       o_res_stb,
    output t_res                       o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROWS = (MAX_CONTROLS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(NUM_CELLS + 1);

    t_state              r_state;
    t_state              n_state;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W-1:0]    n_row;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic                r_scan_vld;
    logic [ROW_W-1:0]    r_scan_row;
    logic [SCORE_W-1:0]  r_case_score;
    logic [FU_W-1:0]     r_case_fu;
    logic [CALIPER_W-1:0] r_caliper;
    logic [FU_W-1:0]     r_window;
    logic                r_res_stb;
    t_res                r_res;

    t_op                 op_code;
    logic                accept;
    logic                ld_ok;
    logic                is_load;
    logic                is_match;
    logic                row_last;
    logic                cnt_last;
    logic [CELL_W-1:0]   ld_cell;
    logic [ENTRY_W-1:0]  ld_row_full;
    logic [ENTRY_W-1:0]  win_row_full;
    logic [CELL_W-1:0]   win_cell;
    logic [ROW_W-1:0]    wr_row;
    t_cand               win;
    t_cell_ctl           ctl [NUM_CELLS];
    t_cand               chain_in [NUM_CELLS];
    t_cand               chain_out [NUM_CELLS];

    assign op_code = t_op'(i_cmd.operation);
    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;
    assign ld_ok = (32'(i_cmd.entry_index) < 32'(MAX_CONTROLS));
    assign is_load = accept && (op_code == OP_LOAD) && ld_ok;
    assign is_match = accept && (op_code == OP_MATCH);
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign cnt_last = (r_cnt == CNT_W'(NUM_CELLS));
    assign ld_cell = i_cmd.entry_index[CELL_W-1:0];
    assign ld_row_full = i_cmd.entry_index >> CELL_W;
    assign win = chain_out[NUM_CELLS-1];
    assign win_cell = win.gidx[CELL_W-1:0];
    assign win_row_full = win.gidx >> CELL_W;

    always_comb begin
        n_state = r_state;
        n_row = r_row;
        n_cnt = r_cnt;
        unique case (r_state)
            ST_CLEAR: begin
                n_row = r_row + 1'b1;
                if (row_last) begin
                    n_state = ST_IDLE;
                    n_row = '0;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (op_code)
                        OP_MATCH: begin
                            n_state = ST_SCAN;
                            n_row = '0;
                        end
                        OP_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_row = '0;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_row = r_row + 1'b1;
                if (row_last) begin
                    n_state = ST_REDUCE;
                    n_row = '0;
                    n_cnt = '0;
                end
            end
            ST_REDUCE: begin
                n_cnt = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_CLEAR: wr_row = r_row;
            ST_WRITE: wr_row = ROW_W'(win_row_full);
            default:  wr_row = ROW_W'(ld_row_full);
        endcase
        for (int k = 0; k < NUM_CELLS; k++) begin
            ctl[k].data_we = is_load && (ld_cell == CELL_W'(k));
            ctl[k].flag_we = (r_state == ST_CLEAR)
                             || (is_load && (ld_cell == CELL_W'(k)))
                             || ((r_state == ST_WRITE) && win.have
                                 && (win_cell == CELL_W'(k)));
            ctl[k].flag_valid = (r_state != ST_CLEAR);
            ctl[k].flag_used = (r_state == ST_WRITE);
            ctl[k].scan_vld = r_scan_vld;
            ctl[k].best_clr = is_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_row <= '0;
            r_cnt <= '0;
            r_scan_vld <= 1'b0;
            r_res_stb <= 1'b0;
            r_caliper <= CALIPER_RST;
            r_window <= WINDOW_RST;
        end else begin
            r_state <= n_state;
            r_row <= n_row;
            r_cnt <= n_cnt;
            r_scan_vld <= (r_state == ST_SCAN);
            r_res_stb <= (r_state == ST_WRITE);
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_CALIPER: r_caliper <= i_cfg_data[CALIPER_W-1:0];
                    CFG_WINDOW:  r_window <= i_cfg_data[FU_W-1:0];
                    default:     r_window <= r_window;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_row <= r_row;
        if (is_match) begin
            r_case_score <= i_cmd.score;
            r_case_fu <= i_cmd.follow_up;
        end
        r_res.found <= win.have;
        r_res.match_index <= win.have ? win.gidx : '0;
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign chain_in[g] = '0;
        end else begin : g_link
            assign chain_in[g] = chain_out[g-1];
        end

        gcnm_cell #(
            .ROWS   (ROWS),
            .ROW_W  (ROW_W),
            .CELL_ID(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl[g]),
            .i_wr_row    (wr_row),
            .i_rd_row    (r_row),
            .i_scan_row  (r_scan_row),
            .i_ld_score  (i_cmd.score),
            .i_ld_fu     (i_cmd.follow_up),
            .i_case_score(r_case_score),
            .i_case_fu   (r_case_fu),
            .i_caliper   (r_caliper),
            .i_window    (r_window),
            .i_chain     (chain_in[g]),
            .o_chain     (chain_out[g])
        );
    end

    assign o_res_stb = r_res_stb;
    assign o_res = r_res;

    a_res_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_stb |-> $past(r_state == ST_WRITE))
        else $error("Result beat without a write-back cycle.");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_stb && !r_res.found) |-> (r_res.match_index == '0))
        else $error("No-match beat carries a nonzero index.");

    a_win_in_caliper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WRITE) && win.have) |-> ({1'b0, win.score_gap} < r_caliper))
        else $error("Winner lies outside the caliper.");

    a_match_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_match |=> (o_busy && (r_state == ST_SCAN)))
        else $error("Match beat did not start a scan.");

endmodule
`default_nettype wire

@@ tb/tb_greedy_caliper_nearest_match.sv @@
`timescale 1ns / 100ps
module tb_greedy_caliper_nearest_match;
    import gcnm_pkg::*;

    localparam int TBL_DEPTH = MAX_CONTROLS_DEF;
    localparam int DRAIN_CYCLES = TBL_DEPTH / 8 + 32;
    localparam int STALL_LIMIT = 20 * DRAIN_CYCLES;
    localparam int RANDOM_ITEMS = 450;
    localparam int NUM_PHASES = 6;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        bit                    cfg_row;
        t_cfg_reg              sel;
        logic [CFG_DATA_W-1:0] val;
        t_cmd                  c;
        bit                    typed;
        t_res                  want;
    } t_step;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_cmd                  cmd;
    logic                  res_stb;
    t_res                  res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit [SCORE_W-1:0]   tbl_score [TBL_DEPTH];
    bit [FU_W-1:0]      tbl_fu [TBL_DEPTH];
    bit                 tbl_valid [TBL_DEPTH];
    bit                 tbl_used [TBL_DEPTH];
    bit [CALIPER_W-1:0] cal_q = CALIPER_RST;
    bit [FU_W-1:0]      win_q = WINDOW_RST;

    t_res  pending_matches [$];
    t_step plan [$];
    int    mismatches = 0;
    int    stall_cycles = 0;
    int    idle_pct = 21;

    int cal_plan [NUM_PHASES] = '{65536, 40, 0, 65535, 1, 3000};
    int win_plan [NUM_PHASES] = '{90, 300, 65535, 65535, 0, 1000};

    greedy_caliper_nearest_match i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_cmd      (cmd),
        .o_res_stb  (res_stb),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned gap(input int unsigned a, input int unsigned b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic bit apply_to_table(input t_cmd c, output t_res r);
        bit          have;
        int          best;
        int unsigned best_dist;
        int unsigned d;
        r = '0;
        have = 1'b0;
        best = 0;
        best_dist = 0;
        case (c.operation)
            OP_LOAD: begin
                tbl_score[c.entry_index] = c.score;
                tbl_fu[c.entry_index] = c.follow_up;
                tbl_valid[c.entry_index] = 1'b1;
                tbl_used[c.entry_index] = 1'b0;
            end
            OP_CLEAR: begin
                for (int j = 0; j < TBL_DEPTH; j++) begin
                    tbl_valid[j] = 1'b0;
                    tbl_used[j] = 1'b0;
                end
            end
            OP_MATCH: begin
                for (int j = 0; j < TBL_DEPTH; j++) begin
                    if (!tbl_valid[j] || tbl_used[j]) continue;
                    if (gap(c.follow_up, tbl_fu[j]) > win_q) continue;
                    d = gap(c.score, tbl_score[j]);
                    if (d >= cal_q) continue;
                    if (!have || d < best_dist) begin
                        have = 1'b1;
                        best = j;
                        best_dist = d;
                    end
                end
                if (have) begin
                    tbl_used[best] = 1'b1;
                    r.found = 1'b1;
                    r.match_index = ENTRY_W'(best);
                end
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void add_cmd(input logic [1:0] op, input int idx, input int sc,
                                    input int fu, input bit typed = 1'b0,
                                    input bit found = 1'b0, input int midx = 0);
        t_step s;
        s.cfg_row = 1'b0;
        s.sel = CFG_CALIPER;
        s.val = '0;
        s.c.operation = op;
        s.c.entry_index = ENTRY_W'(idx);
        s.c.score = SCORE_W'(sc);
        s.c.follow_up = FU_W'(fu);
        s.typed = typed;
        s.want.found = found;
        s.want.match_index = ENTRY_W'(midx);
        plan.push_back(s);
    endfunction

    function automatic void add_cfg(input t_cfg_reg sel, input int v);
        t_step s;
        s.cfg_row = 1'b1;
        s.sel = sel;
        s.val = CFG_DATA_W'(v);
        s.c = '0;
        s.typed = 1'b0;
        s.want = '0;
        plan.push_back(s);
    endfunction

    function automatic t_cmd random_item(input logic [SCORE_W-1:0] sc_ctr,
                                         input logic [FU_W-1:0] fu_ctr,
                                         input int sc_spread, input int fu_spread);
        t_cmd        c;
        int unsigned k;
        k = $urandom_range(0, 99);
        c.entry_index = ENTRY_W'($urandom_range(0, TBL_DEPTH - 1));
        if ($urandom_range(0, 4) == 0) c.score = SCORE_W'($urandom_range(0, 65535));
        else c.score = sc_ctr + SCORE_W'($urandom_range(0, sc_spread));
        if ($urandom_range(0, 4) == 0) c.follow_up = FU_W'($urandom_range(0, 65535));
        else c.follow_up = fu_ctr + FU_W'($urandom_range(0, fu_spread));
        if (k < 58) c.operation = OP_LOAD;
        else if (k < 90) c.operation = OP_MATCH;
        else if (k < 96) c.operation = OP_SPARE;
        else c.operation = OP_CLEAR;
        return c;
    endfunction

    task automatic send_item(input t_cmd c, input bit typed, input t_res want);
        t_res r;
        while ($urandom_range(0, 99) < idle_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        cmd = c;
        do @(posedge clk); while (busy);
        if (apply_to_table(c, r)) pending_matches.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending_matches.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_idx = sel;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        if (sel == CFG_CALIPER) cal_q = v;
        else win_q = v[FU_W-1:0];
    endtask

    function automatic void note_mismatch(input string what, input t_res want, input t_res got);
        if (mismatches < 10) begin
            $display("mismatch on %s: expected found=%0d index=%0d, got found=%0d index=%0d",
                     what, want.found, want.match_index, got.found, got.match_index);
        end
        mismatches++;
    endfunction

    always @(posedge clk) begin
        t_res want;
        if (rst_n && res_stb) begin
            if (pending_matches.size() == 0) begin
                note_mismatch("unexpected beat", '0, res);
            end else begin
                want = pending_matches.pop_front();
                if (res.found !== want.found) note_mismatch("found", want, res);
                if (res.match_index !== want.match_index) note_mismatch("match_index", want, res);
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || res_stb) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_greedy_caliper_nearest_match: done, errors");
            $finish;
        end
    end

    initial begin
        logic [SCORE_W-1:0] sc_ctr;
        logic [FU_W-1:0]    fu_ctr;
        int                 sc_spread;
        int                 fu_spread;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // An empty table, then the corners of the score and follow-up ranges.
        add_cmd(OP_MATCH, 0, 16'h8000, 100, 1, 0, 0);
        add_cmd(OP_LOAD, 0, 0, 0);
        add_cmd(OP_LOAD, 1023, 16'hFFFF, 16'hFFFF);
        add_cmd(OP_MATCH, 0, 16'hFFFF, 16'hFFFF, 1, 1, 1023);
        add_cmd(OP_MATCH, 0, 16'hFFFF, 16'hFFFF, 1, 0, 0);
        add_cmd(OP_MATCH, 0, 0, 90, 1, 1, 0);
        // Equal distances go to the lower slot; a follow-up one day outside fails.
        add_cmd(OP_LOAD, 5, 100, 1000);
        add_cmd(OP_LOAD, 3, 300, 1000);
        add_cmd(OP_MATCH, 0, 200, 1000, 1, 1, 3);
        add_cmd(OP_MATCH, 0, 200, 1091, 1, 0, 0);
        add_cmd(OP_MATCH, 0, 250, 1000);
        // Reloading a used slot makes it available again.
        add_cmd(OP_LOAD, 0, 0, 0);
        add_cmd(OP_MATCH, 0, 65535, 0, 1, 1, 0);
        add_cmd(OP_SPARE, 1023, 16'hFFFF, 16'hFFFF);
        add_cmd(OP_CLEAR, 0, 0, 0);
        add_cmd(OP_MATCH, 0, 100, 1000, 1, 0, 0);
        add_cmd(OP_LOAD, 10'h2AA, 16'h5555, 16'hAAAA);
        add_cmd(OP_LOAD, 10'h155, 16'hAAAA, 16'h5555);
        add_cmd(OP_MATCH, 0, 16'h5555, 16'hAAAA, 1, 1, 10'h2AA);
        add_cfg(CFG_CALIPER, 0);
        add_cmd(OP_MATCH, 0, 16'hAAAA, 16'h5555, 1, 0, 0);
        add_cfg(CFG_CALIPER, 1);
        add_cmd(OP_MATCH, 0, 16'hAAAA, 16'h5555, 1, 1, 10'h155);
        add_cmd(OP_LOAD, 7, 1000, 500);
        add_cfg(CFG_WINDOW, 0);
        add_cmd(OP_MATCH, 0, 1000, 501, 1, 0, 0);
        add_cmd(OP_MATCH, 0, 1000, 500, 1, 1, 7);

        foreach (plan[i]) begin
            if (plan[i].cfg_row) write_reg(plan[i].sel, plan[i].val);
            else send_item(plan[i].c, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_CALIPER, CFG_DATA_W'(cal_plan[p]));
            write_reg(CFG_WINDOW, CFG_DATA_W'(win_plan[p]));
            idle_pct = (p < 2) ? 21 : (p < 4) ? 88 : 0;
            sc_ctr = SCORE_W'($urandom_range(0, 65535));
            fu_ctr = FU_W'($urandom_range(0, 65535));
            sc_spread = (cal_plan[p] < 100) ? 3 : 255;
            fu_spread = (win_plan[p] == 0) ? 3 : 120;
            for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++) begin
                if ($urandom_range(0, 49) == 0) drain();
                send_item(random_item(sc_ctr, fu_ctr, sc_spread, fu_spread), 1'b0, '0);
            end
        end

        drain();
        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("tb_greedy_caliper_nearest_match: done, clean");
        end else begin
            $display("tb_greedy_caliper_nearest_match: done, errors");
        end
        $finish;
    end

endmodule

@@ greedy_caliper_nearest_match.f @@
hdl/gcnm_pkg.sv
hdl/gcnm_ram.sv
hdl/gcnm_cell.sv
hdl/greedy_caliper_nearest_match.sv
tb/tb_greedy_caliper_nearest_match.sv
